### design/tagless_line_scratchpad_defines.svh
// Assertion macros shared by the scratchpad modules.
`ifndef TAGLESS_LINE_SCRATCHPAD_DEFINES_SVH
`define TAGLESS_LINE_SCRATCHPAD_DEFINES_SVH

// When the antecedent holds, the consequent holds in the same cycle.
`define TLS_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("scratchpad assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define TLS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("scratchpad assertion failed");

// The expression never holds.
`define TLS_ASSERT_NEVER(lbl, ck, rn, expr) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) \
		else $error("scratchpad assertion failed");

`endif

### design/tls_pkg.sv
// Shared types and constants of the tagless line scratchpad.
`timescale 1ns / 1ps

package tls_pkg;

	typedef enum logic [2:0] {
		OP_RD_WORD  = 3'd0,
		OP_WR_WORD  = 3'd1,
		OP_RD_BYTE  = 3'd2,
		OP_WR_BYTE  = 3'd3,
		OP_INVAL    = 3'd4,
		OP_ENABLE   = 3'd5,
		OP_TEARDOWN = 3'd6,
		OP_NOP      = 3'd7
	} op_e;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADDR,
		ST_LINE,
		ST_LOOK,
		ST_EVAL,
		ST_RD,
		ST_WR,
		ST_INV
	} state_e;

	localparam logic [63:0] TEST_PATTERN = 64'hDEAD_BEEF_CAFE_BABE;
	localparam int WORD_BYTES = 8;
	localparam int SLOT_W = $clog2(WORD_BYTES);
	localparam int CNT_W = $clog2(WORD_BYTES + 1);

endpackage

### design/tls_cdiv.sv
// Quotient and remainder by a constant divisor through reciprocal multiplication.
`timescale 1ns / 1ps
`include "tagless_line_scratchpad_defines.svh"

module tls_cdiv #(
	parameter int IN_W    = 32,
	parameter int DIVISOR = 64
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	input  logic [IN_W-1:0]                           dividend,
	output logic                                      busy,
	output logic [IN_W-($clog2(DIVISOR + 1) - 1)-1:0] quo,
	output logic [IN_W-1:0]                           rem
);

	localparam int SH = $clog2(DIVISOR + 1) - 1;
	localparam int QW = IN_W - SH;
	localparam int RW = QW + 1;
	localparam int PW = IN_W + RW;
	// The scaled reciprocal gives an estimate that is the true quotient or one below it.
	localparam logic [RW-1:0]   RECIP = RW'((64'd1 << IN_W) / 64'(DIVISOR));
	localparam logic [IN_W-1:0] DVAL  = IN_W'(DIVISOR);

	logic                 vld_s1;
	logic [IN_W-1:0]      x_s1;
	logic [PW-1:0]        prod_s1;
	logic                 vld_s2;
	logic [QW-1:0]        quo_s2;
	logic [IN_W-1:0]      rem_s2;
	logic [QW-1:0]        quo_q;
	logic [IN_W-1:0]      rem_q;
	logic [QW-1:0]        q_est;
	logic [QW+IN_W-1:0]   qd;
	logic                 ge;

	always_comb begin
		q_est = prod_s1[IN_W +: QW];
		qd    = q_est * DVAL;
		ge    = rem_s2 >= DVAL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_s1    <= dividend;
			prod_s1 <= dividend * RECIP;
		end
		if (vld_s1) begin
			quo_s2 <= q_est;
			rem_s2 <= x_s1 - qd[IN_W-1:0];
		end
		// One conditional subtraction brings the remainder below the divisor.
		if (vld_s2) begin
			if (ge) begin
				rem_q <= rem_s2 - DVAL;
				quo_q <= quo_s2 + QW'(1);
			end else begin
				rem_q <= rem_s2;
				quo_q <= quo_s2;
			end
		end
	end

	assign busy = vld_s1 | vld_s2;
	assign quo  = quo_q;
	assign rem  = rem_q;

	`TLS_ASSERT_NEVER(a_no_restart, clk, arst_n, start && busy)
	`TLS_ASSERT_NEXT(a_start_busy, clk, arst_n, start, vld_s1)
	`TLS_ASSERT_IMPLY(a_rem_reduced, clk, arst_n, $fell(busy), rem_q < DVAL)

endmodule

### design/tagless_line_scratchpad.sv
// Top level of the tagless line scratchpad: sequencer, byte store and valid store.
`timescale 1ns / 1ps
`include "tagless_line_scratchpad_defines.svh"

// Channel   Handshake             Fields
// -------   ---------             ------
// command   start high, busy low  opcode, byte_offset, write_data, block_position
// result    done strobe, 1 cycle  read_data, was_hit, hit_total, miss_total, is_enabled
//
// Reset starts a clearing pass over both stores, one byte per cycle, with busy high. A
// no-op, a repeated enable, or an access or teardown on a disabled store ends at
// acceptance; a first enable writes the test pattern in ST_WR, invalidate and teardown
// clear the lines in ST_INV. An access wraps the offset and finds the line by reciprocal
// multiplication (ST_ADDR, ST_LINE), then writes in ST_WR, or reads in ST_LOOK and ST_EVAL
// and, on a word read hit, in ST_RD. done follows the finishing state; no stall exists.

module tagless_line_scratchpad #(
	parameter int LINES      = 256,
	parameter int LINE_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [31:0] byte_offset,
	input  logic [63:0] write_data,
	input  logic [31:0] block_position,
	output logic        done,
	output logic [63:0] read_data,
	output logic        was_hit,
	output logic [31:0] hit_total,
	output logic [31:0] miss_total,
	output logic        is_enabled
);

	localparam int STORE_BYTES = LINES * LINE_BYTES;
	localparam int AW  = $clog2(STORE_BYTES);
	localparam int LW  = $clog2(LINES);
	localparam int LQW = AW - ($clog2(LINE_BYTES + 1) - 1);
	localparam int CW  = tls_pkg::CNT_W;
	localparam int SW  = tls_pkg::SLOT_W;

	// Sequencer state and counters.
	tls_pkg::state_e state_q, state_d;
	logic [AW-1:0]   clr_q;
	logic [LW-1:0]   inv_q;
	logic [CW-1:0]   cnt_q;
	logic            en_q;
	logic [31:0]     hits_q;
	logic [31:0]     misses_q;
	logic            done_q;

	// The command being worked on.
	tls_pkg::op_e    op_q;
	tls_pkg::op_e    op_in;
	logic [63:0]     wd_q;
	logic [AW-1:0]   addr_q;
	logic [LW-1:0]   line_q;
	logic [63:0]     word_q;
	logic [63:0]     rdata_q;
	logic            hit_q;

	// Memory ports.
	logic [7:0]      byte_mem [STORE_BYTES];
	logic            line_mem [LINES];
	logic            bm_we, bm_re;
	logic [AW-1:0]   bm_addr;
	logic [7:0]      bm_wdata;
	logic [7:0]      bm_rdata_q;
	logic            vm_we, vm_re;
	logic [LW-1:0]   vm_addr;
	logic            vm_wdata;
	logic            vm_rdata_q;

	// Divider hookup.
	logic            unit_start, line_start;
	logic            mod_busy, pos_busy, line_busy;
	logic [31:0]     mod_rem, pos_rem;
	logic [LQW-1:0]  line_quo;
	logic            pos_zero;

	// Result and control strobes.
	logic            accept;
	logic            fin;
	logic [63:0]     fin_rd;
	logic            fin_hit;
	logic            inc_hit, inc_miss;
	logic [AW-1:0]   addr_nx;
	logic [SW-1:0]   rd_slot;

	assign op_in    = tls_pkg::op_e'(opcode);
	assign pos_zero = (pos_rem == 32'd0);
	assign addr_nx  = (addr_q == AW'(STORE_BYTES - 1)) ? '0 : addr_q + AW'(1);
	assign rd_slot  = SW'(cnt_q - CW'(1));

	// The offset wraps modulo the store size; the block position is checked
	// against the line size in parallel.
	tls_cdiv #(.IN_W(32), .DIVISOR(STORE_BYTES)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (unit_start),
		.dividend (byte_offset),
		.busy     (mod_busy),
		.quo      (),
		.rem      (mod_rem)
	);

	tls_cdiv #(.IN_W(32), .DIVISOR(LINE_BYTES)) u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (unit_start),
		.dividend (block_position),
		.busy     (pos_busy),
		.quo      (),
		.rem      (pos_rem)
	);

	// The wrapped address divided by the line size gives the line index.
	tls_cdiv #(.IN_W(AW), .DIVISOR(LINE_BYTES)) u_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (line_start),
		.dividend (mod_rem[AW-1:0]),
		.busy     (line_busy),
		.quo      (line_quo),
		.rem      ()
	);

	// Byte store and valid store: one port each, registered read data.
	// Accesses never overlap, since each write finishes before the next read issues.
	always_ff @(posedge clk) begin
		if (bm_we) begin
			byte_mem[bm_addr] <= bm_wdata;
		end
		if (bm_re) begin
			bm_rdata_q <= byte_mem[bm_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (vm_we) begin
			line_mem[vm_addr] <= vm_wdata;
		end
		if (vm_re) begin
			vm_rdata_q <= line_mem[vm_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tls_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory controls and the result of the finishing cycle.
	always_comb begin
		state_d    = state_q;
		accept     = 1'b0;
		bm_we      = 1'b0;
		bm_re      = 1'b0;
		bm_addr    = addr_q;
		bm_wdata   = wd_q[8*cnt_q[SW-1:0] +: 8];
		vm_we      = 1'b0;
		vm_re      = 1'b0;
		vm_addr    = line_q;
		vm_wdata   = 1'b0;
		unit_start = 1'b0;
		line_start = 1'b0;
		fin        = 1'b0;
		fin_rd     = '0;
		fin_hit    = 1'b0;
		inc_hit    = 1'b0;
		inc_miss   = 1'b0;
		unique case (state_q)
			tls_pkg::ST_CLEAR: begin
				bm_we    = 1'b1;
				bm_addr  = clr_q;
				bm_wdata = '0;
				vm_we    = (clr_q < AW'(LINES));
				vm_addr  = clr_q[LW-1:0];
				if (clr_q == AW'(STORE_BYTES - 1)) begin
					state_d = tls_pkg::ST_IDLE;
				end
			end
			tls_pkg::ST_IDLE: begin
				if (start) begin
					accept = 1'b1;
					unique case (op_in)
						tls_pkg::OP_RD_WORD, tls_pkg::OP_WR_WORD,
						tls_pkg::OP_RD_BYTE, tls_pkg::OP_WR_BYTE: begin
							if (en_q) begin
								unit_start = 1'b1;
								state_d    = tls_pkg::ST_ADDR;
							end else begin
								fin = 1'b1;
							end
						end
						tls_pkg::OP_INVAL: begin
							state_d = tls_pkg::ST_INV;
						end
						tls_pkg::OP_ENABLE: begin
							if (en_q) begin
								fin = 1'b1;
							end else begin
								state_d = tls_pkg::ST_WR;
							end
						end
						tls_pkg::OP_TEARDOWN: begin
							if (en_q) begin
								state_d = tls_pkg::ST_INV;
							end else begin
								fin = 1'b1;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			tls_pkg::ST_ADDR: begin
				if (!mod_busy && !pos_busy) begin
					line_start = 1'b1;
					state_d    = tls_pkg::ST_LINE;
				end
			end
			tls_pkg::ST_LINE: begin
				if (!line_busy) begin
					if (op_q == tls_pkg::OP_WR_WORD || op_q == tls_pkg::OP_WR_BYTE) begin
						state_d = tls_pkg::ST_WR;
					end else begin
						state_d = tls_pkg::ST_LOOK;
					end
				end
			end
			tls_pkg::ST_LOOK: begin
				vm_re   = 1'b1;
				bm_re   = 1'b1;
				state_d = tls_pkg::ST_EVAL;
			end
			tls_pkg::ST_EVAL: begin
				if (op_q == tls_pkg::OP_RD_BYTE) begin
					fin      = 1'b1;
					fin_hit  = vm_rdata_q;
					fin_rd   = vm_rdata_q ? {56'd0, bm_rdata_q} : 64'd0;
					inc_hit  = pos_zero && vm_rdata_q;
					inc_miss = pos_zero && !vm_rdata_q;
					state_d  = tls_pkg::ST_IDLE;
				end else if (vm_rdata_q) begin
					state_d = tls_pkg::ST_RD;
				end else begin
					fin      = 1'b1;
					inc_miss = 1'b1;
					state_d  = tls_pkg::ST_IDLE;
				end
			end
			tls_pkg::ST_RD: begin
				bm_re = (cnt_q < CW'(tls_pkg::WORD_BYTES));
				if (cnt_q == CW'(tls_pkg::WORD_BYTES)) begin
					fin     = 1'b1;
					fin_hit = 1'b1;
					inc_hit = 1'b1;
					fin_rd  = {bm_rdata_q, word_q[55:0]};
					state_d = tls_pkg::ST_IDLE;
				end
			end
			tls_pkg::ST_WR: begin
				bm_we    = 1'b1;
				vm_we    = (cnt_q == '0);
				vm_wdata = 1'b1;
				if (op_q == tls_pkg::OP_WR_BYTE ||
				    cnt_q == CW'(tls_pkg::WORD_BYTES - 1)) begin
					fin     = 1'b1;
					state_d = tls_pkg::ST_IDLE;
					if (op_q == tls_pkg::OP_ENABLE) begin
						// The enable reports the test pattern as read data and counts it as a hit.
						fin_rd  = tls_pkg::TEST_PATTERN;
						fin_hit = 1'b1;
						inc_hit = 1'b1;
					end
				end
			end
			tls_pkg::ST_INV: begin
				vm_we   = 1'b1;
				vm_addr = inv_q;
				if (inv_q == LW'(LINES - 1)) begin
					fin     = 1'b1;
					state_d = tls_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tls_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			inv_q    <= '0;
			cnt_q    <= '0;
			en_q     <= 1'b0;
			hits_q   <= '0;
			misses_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= fin;
			if (state_q == tls_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == tls_pkg::ST_INV) begin
				inv_q <= inv_q + LW'(1);
			end else begin
				inv_q <= '0;
			end
			if (state_q == tls_pkg::ST_RD || state_q == tls_pkg::ST_WR) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (accept && op_in == tls_pkg::OP_ENABLE) begin
				en_q <= 1'b1;
			end else if (state_q == tls_pkg::ST_INV && fin &&
			             op_q == tls_pkg::OP_TEARDOWN) begin
				en_q <= 1'b0;
			end
			if (inc_hit) begin
				hits_q <= hits_q + 32'd1;
			end
			if (inc_miss) begin
				misses_q <= misses_q + 32'd1;
			end
		end
	end

	// Payload registers of the transaction in flight.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_in;
			if (op_in == tls_pkg::OP_ENABLE) begin
				wd_q   <= tls_pkg::TEST_PATTERN;
				addr_q <= '0;
				line_q <= '0;
			end else begin
				wd_q <= write_data;
			end
		end
		if (state_q == tls_pkg::ST_ADDR && line_start) begin
			addr_q <= mod_rem[AW-1:0];
		end
		if (state_q == tls_pkg::ST_LINE && !line_busy) begin
			line_q <= line_quo[LW-1:0];
		end
		if ((state_q == tls_pkg::ST_RD && bm_re) || state_q == tls_pkg::ST_WR) begin
			addr_q <= addr_nx;
		end
		if (state_q == tls_pkg::ST_RD && cnt_q != '0) begin
			word_q[8*rd_slot +: 8] <= bm_rdata_q;
		end
		if (fin) begin
			rdata_q <= fin_rd;
			hit_q   <= fin_hit;
		end
	end

	assign busy       = (state_q != tls_pkg::ST_IDLE);
	assign done       = done_q;
	assign read_data  = rdata_q;
	assign was_hit    = hit_q;
	assign hit_total  = hits_q;
	assign miss_total = misses_q;
	assign is_enabled = en_q;

	`TLS_ASSERT_IMPLY(a_done_idle, clk, arst_n, done_q, state_q == tls_pkg::ST_IDLE)
	`TLS_ASSERT_NEVER(a_one_count, clk, arst_n, inc_hit && inc_miss)
	`TLS_ASSERT_NEXT(a_count_fin, clk, arst_n, !fin, $stable(hits_q) && $stable(misses_q))
	`TLS_ASSERT_IMPLY(a_teardown_off, clk, arst_n, done_q && op_q == tls_pkg::OP_TEARDOWN, !en_q)

endmodule
